>>> hw/rtl/mri_pkg.sv
// Shared types and constants for the modular reduce and inverse core.
package mri_pkg;

  // Datapath word width
  localparam int unsigned DW = 64;

  // Operation codes
  localparam logic [1:0] FN_NONNEG  = 2'd0;
  localparam logic [1:0] FN_CENTRED = 2'd1;
  localparam logic [1:0] FN_INVERSE = 2'd2;

  // Status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_DIV0  = 2'd1;
  localparam logic [1:0] ST_NOINV = 2'd2;

  // Controller states
  typedef enum logic [3:0] {
    S_IDLE,
    S_DISP,
    S_DIVA,
    S_CHK,
    S_DIVE,
    S_WCONST,
    S_WREM,
    S_WINV
  } state_t;

  // Datapath commands
  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_DIV_AB,
    CMD_DIV_IJ,
    CMD_STEP,
    CMD_EUC_INIT,
    CMD_EUC_UPD,
    CMD_WR_CONST,
    CMD_WR_REM,
    CMD_WR_INV
  } cmd_t;

  // Datapath status toward the controller
  typedef struct packed {
    logic       special;   // zero modulus or unused operation code
    logic [1:0] func;
    logic       div_busy;
    logic       j_pos;
  } dp_stat_t;

endpackage

>>> hw/rtl/mri_datapath.sv
// Datapath: operand registers, shift-subtract divider with cofactor accumulation, result.
module mri_datapath (
  input  logic                          clk,
  input  mri_pkg::cmd_t                 cmd,
  input  logic [1:0]                    in_func,
  input  logic signed [mri_pkg::DW-1:0] in_value,
  input  logic signed [mri_pkg::DW-1:0] in_modulus,
  output mri_pkg::dp_stat_t             stat,
  output logic signed [mri_pkg::DW-1:0] res,
  output logic [1:0]                    st
);

  localparam int unsigned CW = $clog2(mri_pkg::DW + 1);

  logic [1:0]                    func_r;
  logic signed [mri_pkg::DW-1:0] a_r, b_r, i_r, j_r, y1_r, y2_r;
  logic [mri_pkg::DW-1:0]        num_r, den_r, rem_r, mul_r, prod_r;
  logic                          neg_q_r, neg_r_r;
  logic [CW-1:0]                 cnt_r;
  logic signed [mri_pkg::DW-1:0] res_r;
  logic [1:0]                    st_r;

  logic [mri_pkg::DW:0]          sh, diff;
  logic                          ge;
  logic signed [mri_pkg::DW-1:0] r_s, p_s, nonneg, centred, lo, hi, negb, bm1;
  logic signed [mri_pkg::DW-1:0] dn, dd, dm;

  function automatic logic [mri_pkg::DW-1:0] mag(input logic signed [mri_pkg::DW-1:0] x);
    mag = x[mri_pkg::DW-1] ? (~x + 1'b1) : x;
  endfunction

  // Truncating halving of a signed word
  function automatic logic signed [mri_pkg::DW-1:0] half(
    input logic signed [mri_pkg::DW-1:0] x);
    logic signed [mri_pkg::DW-1:0] t;
    t = x + {{(mri_pkg::DW-1){1'b0}}, x[mri_pkg::DW-1]};
    half = t >>> 1;
  endfunction

  // One restoring division step
  always_comb begin
    sh   = {rem_r, num_r[mri_pkg::DW-1]};
    diff = sh - {1'b0, den_r};
    ge   = !diff[mri_pkg::DW];
  end

  // Signed remainder and signed product of the finished division
  always_comb begin
    r_s     = neg_r_r ? -$signed(rem_r) : $signed(rem_r);
    p_s     = neg_q_r ? -$signed(prod_r) : $signed(prod_r);
    nonneg  = (r_s < 0) ? r_s + b_r : r_s;
    negb    = -b_r;
    bm1     = b_r - 1;
    lo      = half(negb);
    hi      = half(bm1);
    if (r_s < lo) begin
      centred = r_s + b_r;
    end else if (r_s > hi) begin
      centred = r_s - b_r;
    end else begin
      centred = r_s;
    end
  end

  // Select divider operands
  always_comb begin
    if (cmd == mri_pkg::CMD_DIV_IJ) begin
      dn = i_r;
      dd = j_r;
      dm = y1_r;
    end else begin
      dn = a_r;
      dd = b_r;
      dm = '0;
    end
  end

  // Registers
  always_ff @(posedge clk) begin
    case (cmd)
      mri_pkg::CMD_LOAD: begin
        func_r <= in_func;
        a_r    <= in_value;
        b_r    <= in_modulus;
        cnt_r  <= '0;
      end
      mri_pkg::CMD_DIV_AB, mri_pkg::CMD_DIV_IJ: begin
        num_r   <= mag(dn);
        den_r   <= mag(dd);
        rem_r   <= '0;
        mul_r   <= dm;
        prod_r  <= '0;
        neg_r_r <= dn[mri_pkg::DW-1];
        neg_q_r <= dn[mri_pkg::DW-1] ^ dd[mri_pkg::DW-1];
        cnt_r   <= CW'(mri_pkg::DW);
      end
      mri_pkg::CMD_STEP: begin
        rem_r  <= ge ? diff[mri_pkg::DW-1:0] : sh[mri_pkg::DW-1:0];
        num_r  <= num_r << 1;
        prod_r <= (prod_r << 1) + (ge ? mul_r : '0);
        cnt_r  <= cnt_r - 1'b1;
      end
      mri_pkg::CMD_EUC_INIT: begin
        i_r  <= b_r;
        j_r  <= nonneg;
        y2_r <= '0;
        y1_r <= {{(mri_pkg::DW-1){1'b0}}, 1'b1};
      end
      mri_pkg::CMD_EUC_UPD: begin
        i_r  <= j_r;
        j_r  <= r_s;
        y2_r <= y1_r;
        y1_r <= y2_r - p_s;
      end
      mri_pkg::CMD_WR_CONST: begin
        if (func_r == mri_pkg::FN_INVERSE) begin
          res_r <= a_r;
          st_r  <= mri_pkg::ST_OK;
        end else if (func_r == mri_pkg::FN_NONNEG || func_r == mri_pkg::FN_CENTRED) begin
          res_r <= '0;
          st_r  <= mri_pkg::ST_DIV0;
        end else begin
          res_r <= '0;
          st_r  <= mri_pkg::ST_OK;
        end
      end
      mri_pkg::CMD_WR_REM: begin
        res_r <= (func_r == mri_pkg::FN_CENTRED) ? centred : nonneg;
        st_r  <= mri_pkg::ST_OK;
      end
      mri_pkg::CMD_WR_INV: begin
        if (i_r != 1) begin
          res_r <= '0;
          st_r  <= mri_pkg::ST_NOINV;
        end else begin
          res_r <= (y2_r < 0) ? y2_r + b_r : y2_r;
          st_r  <= mri_pkg::ST_OK;
        end
      end
      default: begin
      end
    endcase
  end

  // Status toward the controller
  always_comb begin
    stat.special  = (b_r == 0) || (func_r != mri_pkg::FN_NONNEG &&
                    func_r != mri_pkg::FN_CENTRED && func_r != mri_pkg::FN_INVERSE);
    stat.func     = func_r;
    stat.div_busy = (cnt_r != '0);
    stat.j_pos    = (j_r > 0);
  end

  assign res = res_r;
  assign st  = st_r;

endmodule

>>> hw/rtl/mri_ctrl.sv
// Controller: sequences reduction, Euclid iterations and the output transaction.
module mri_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  input  mri_pkg::dp_stat_t stat,
  output mri_pkg::cmd_t     cmd
);

  mri_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            slot_free;

  assign slot_free = !out_valid_r || out_tready;

  // State and output-valid registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mri_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt     = state_r;
    cmd           = mri_pkg::CMD_NONE;
    out_valid_nxt = out_valid_r && !out_tready;
    case (state_r)
      mri_pkg::S_IDLE: begin
        if (in_tvalid) begin
          cmd       = mri_pkg::CMD_LOAD;
          state_nxt = mri_pkg::S_DISP;
        end
      end
      mri_pkg::S_DISP: begin
        if (stat.special) begin
          state_nxt = mri_pkg::S_WCONST;
        end else begin
          cmd       = mri_pkg::CMD_DIV_AB;
          state_nxt = mri_pkg::S_DIVA;
        end
      end
      mri_pkg::S_DIVA: begin
        if (stat.div_busy) begin
          cmd = mri_pkg::CMD_STEP;
        end else if (stat.func == mri_pkg::FN_INVERSE) begin
          cmd       = mri_pkg::CMD_EUC_INIT;
          state_nxt = mri_pkg::S_CHK;
        end else begin
          state_nxt = mri_pkg::S_WREM;
        end
      end
      mri_pkg::S_CHK: begin
        if (stat.j_pos) begin
          cmd       = mri_pkg::CMD_DIV_IJ;
          state_nxt = mri_pkg::S_DIVE;
        end else begin
          state_nxt = mri_pkg::S_WINV;
        end
      end
      mri_pkg::S_DIVE: begin
        if (stat.div_busy) begin
          cmd = mri_pkg::CMD_STEP;
        end else begin
          cmd       = mri_pkg::CMD_EUC_UPD;
          state_nxt = mri_pkg::S_CHK;
        end
      end
      mri_pkg::S_WCONST, mri_pkg::S_WREM, mri_pkg::S_WINV: begin
        if (slot_free) begin
          if (state_r == mri_pkg::S_WCONST) begin
            cmd = mri_pkg::CMD_WR_CONST;
          end else if (state_r == mri_pkg::S_WREM) begin
            cmd = mri_pkg::CMD_WR_REM;
          end else begin
            cmd = mri_pkg::CMD_WR_INV;
          end
          out_valid_nxt = 1'b1;
          state_nxt     = mri_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = mri_pkg::S_IDLE;
      end
    endcase
  end

  assign in_tready  = (state_r == mri_pkg::S_IDLE);
  assign out_tvalid = out_valid_r;

`ifndef SYNTH
  a_accept_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == mri_pkg::S_DISP))
    else $error("accepted transaction did not reach dispatch");
  a_write_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd == mri_pkg::CMD_WR_CONST || cmd == mri_pkg::CMD_WR_REM ||
     cmd == mri_pkg::CMD_WR_INV) |-> slot_free)
    else $error("result written over a pending output");
  a_div_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mri_pkg::S_DIVA && stat.div_busy) |=> (state_r == mri_pkg::S_DIVA))
    else $error("left reduction before division finished");
`endif

endmodule

>>> hw/rtl/modular_reduce_and_inverse_core.sv
// Top level of the modular reduce and inverse core.
// Takes one request at a time and returns one result per request. A remainder
// request runs one shift-subtract division plus dispatch and write. Each Euclid
// iteration of an inverse request adds one full division with the cofactor
// product accumulated in the same pass, plus a check and an update step; the
// shared bit-serial divider serves the reduction and every Euclid division.
// A finished result waits in the output register while the next request is
// accepted. Zero moduli and the unused operation code skip the division.
module modular_reduce_and_inverse_core (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,   // value [63:0], modulus [127:64]
  input  logic [1:0]   in_tuser,   // func [1:0]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [63:0]  out_tdata,  // result [63:0]
  output logic [1:0]   out_tuser   // status [1:0]
);

  mri_pkg::cmd_t     cmd;
  mri_pkg::dp_stat_t stat;
  logic signed [mri_pkg::DW-1:0] res;

  mri_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  mri_datapath u_dp (
    .clk        (clk),
    .cmd        (cmd),
    .in_func    (in_tuser),
    .in_value   (in_tdata[mri_pkg::DW-1:0]),
    .in_modulus (in_tdata[64 +: mri_pkg::DW]),
    .stat       (stat),
    .res        (res),
    .st         (out_tuser)
  );

  // Drive the result bus with the datapath word (both are 64 bits wide)
  assign out_tdata = 64'(res);

endmodule
